// File: rtl/opm_pkg.sv
// Shared types, constants and saturation helpers for the off-axis projection block.
package opm_pkg;

  localparam int SCREEN_COUNT_DEF = 3;
  localparam int CFG_W            = 31;
  localparam int DATA_W           = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_DISPLAY_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_NEAR_CLIP      = 2'd2;
  localparam logic [1:0] CFG_FAR_CLIP       = 2'd3;

  localparam logic [CFG_W-1:0] DISPLAY_WIDTH_RST  = 31'd19661;
  localparam logic [CFG_W-1:0] DISPLAY_HEIGHT_RST = 31'd13107;
  localparam logic [CFG_W-1:0] NEAR_CLIP_RST      = 31'd655;
  localparam logic [CFG_W-1:0] FAR_CLIP_RST       = 31'd655360;

  // Screen codes
  localparam logic [1:0] SCR_NORTH = 2'd0;
  localparam logic [1:0] SCR_WEST  = 2'd1;
  localparam logic [1:0] SCR_EAST  = 2'd2;

  localparam logic signed [31:0] Q_ONE  = 32'sd65536;
  localparam logic signed [31:0] Q_MAX  = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } eye_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
    logic        neg;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
    logic               zdiv;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sh7fff_ffff) begin
      return Q_MAX;
    end else if (v < -50'sh8000_0000) begin
      return Q_MIN;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    if (v == Q_MIN) begin
      return Q_MAX;
    end
    return -v;
  endfunction

endpackage

// File: rtl/opm_front.sv
// Input stage: accepts eye positions into a two-entry queue for the back end.
module opm_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  opm_pkg::eye_t in_eye,
  output logic          q_valid,
  output opm_pkg::eye_t q_eye,
  input  logic          q_pop
);
  import opm_pkg::*;

  eye_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       push;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_eye    = mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_eye;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// File: rtl/opm_div.sv
// Iterative rounding divider: 64-bit magnitude by 33-bit magnitude, signed Q16.16 result.
module opm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  opm_pkg::div_req_t req,
  output opm_pkg::div_rsp_t rsp
);
  import opm_pkg::*;

  logic [32:0] rem_r;
  logic [31:0] quo_r;
  logic [32:0] md_r;
  logic        neg_r, sat_r, zero_r;
  logic        busy_r, done_r;
  logic [4:0]  cnt_r;

  logic [33:0] shifted, diff;
  logic        take;
  logic [32:0] q_rnd;
  logic        up;

  // One quotient bit per cycle
  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, md_r};
  assign take    = (shifted >= {1'b0, md_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        md_r   <= req.den;
        neg_r  <= req.neg;
        rem_r  <= {1'b0, req.num[63:32]};
        quo_r  <= req.num[31:0];
        zero_r <= 1'b0;
        sat_r  <= 1'b0;
        cnt_r  <= '0;
        if (req.den == '0) begin
          zero_r <= (req.num == '0);
          sat_r  <= (req.num != '0);
          done_r <= 1'b1;
        end else if ({1'b0, req.num[63:32]} >= req.den) begin
          sat_r  <= 1'b1;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= take ? diff[32:0] : shifted[32:0];
        quo_r <= {quo_r[30:0], take};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Round half away from zero, then saturate to signed 32 bits
  assign up    = ({rem_r, 1'b0} >= {1'b0, md_r});
  assign q_rnd = {1'b0, quo_r} + {32'd0, up};

  always_comb begin
    rsp.done = done_r;
    rsp.zdiv = done_r && (zero_r || sat_r) && (md_r == '0);
    if (zero_r) begin
      rsp.quot = '0;
    end else if (sat_r) begin
      rsp.quot = neg_r ? Q_MIN : Q_MAX;
    end else if (neg_r) begin
      rsp.quot = (q_rnd > 33'h0_8000_0000) ? Q_MIN : -$signed(q_rnd[31:0]);
    end else begin
      rsp.quot = (q_rnd > 33'h0_7fff_ffff) ? Q_MAX : $signed(q_rnd[31:0]);
    end
  end

endmodule

// File: rtl/opm_back.sv
// Back end: per-screen sequencer that computes frustum terms and emits matrix rows.
module opm_back #(
  parameter int SCREEN_COUNT = opm_pkg::SCREEN_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [opm_pkg::CFG_W-1:0]   width_q,
  input  logic [opm_pkg::CFG_W-1:0]   height_q,
  input  logic [opm_pkg::CFG_W-1:0]   near_q,
  input  logic [opm_pkg::CFG_W-1:0]   far_q,
  input  logic                        q_valid,
  input  opm_pkg::eye_t               q_eye,
  output logic                        q_pop,
  output opm_pkg::div_req_t           div_req,
  input  opm_pkg::div_rsp_t           div_rsp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_screen_index,
  output logic [1:0]                  out_row_index,
  output logic signed [31:0]          out_elem0,
  output logic signed [31:0]          out_elem1,
  output logic signed [31:0]          out_elem2,
  output logic signed [31:0]          out_elem3,
  output logic                        out_degenerate,
  output logic                        out_last
);
  import opm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // Work steps of one screen
  localparam logic [3:0] STEP_L   = 4'd0;
  localparam logic [3:0] STEP_R   = 4'd1;
  localparam logic [3:0] STEP_B   = 4'd2;
  localparam logic [3:0] STEP_T   = 4'd3;
  localparam logic [3:0] STEP_A   = 4'd4;
  localparam logic [3:0] STEP_C   = 4'd5;
  localparam logic [3:0] STEP_BC  = 4'd6;
  localparam logic [3:0] STEP_D   = 4'd7;
  localparam logic [3:0] STEP_E   = 4'd8;
  localparam logic [3:0] STEP_F   = 4'd9;
  localparam logic [3:0] STEP_AT  = 4'd10;
  localparam logic [3:0] STEP_CT  = 4'd11;
  localparam logic [3:0] STEP_BT  = 4'd12;
  localparam logic [3:0] STEP_DT  = 4'd13;
  localparam logic [3:0] STEP_ET  = 4'd14;
  localparam logic [1:0] LAST_SCR = 2'(SCREEN_COUNT - 1);

  state_t state_r;
  logic [3:0] step_r;
  logic [1:0] scr_r, row_r;
  eye_t       eye_r;
  logic       deg_r;
  logic signed [31:0] l_r, r_r, b_r, t_r, a_r, c_r, bc_r, d_r, e_r, f_r;
  logic signed [31:0] row03_r, row13_r, row23_r;
  logic signed [49:0] acc_r;
  logic [63:0] prod_r;
  logic [32:0] dmag_r;
  logic        neg_r;

  logic signed [34:0] w35, h35, n35, f35, ex2, ey2, ez2;
  logic signed [34:0] d2, lnum, rnum, op_a, op_den;
  logic signed [33:0] op_b, tr, tu, tn;
  logic [34:0] am_w;
  logic [33:0] bm_w;
  logic [34:0] dm_w;
  logic [64:0] prod_w;
  logic [63:0] rnd_sum;
  logic signed [49:0] term;
  logic        is_div, out_load;
  logic signed [31:0] el0, el1, el2, el3;

  // Operand selection for the current step
  always_comb begin
    w35 = {4'b0, width_q};
    h35 = {4'b0, height_q};
    n35 = {4'b0, near_q};
    f35 = {4'b0, far_q};
    ex2 = {{2{eye_r.x[31]}}, eye_r.x, 1'b0};
    ey2 = {{2{eye_r.y[31]}}, eye_r.y, 1'b0};
    ez2 = {{2{eye_r.z[31]}}, eye_r.z, 1'b0};
    tu  = -{{2{eye_r.y[31]}}, eye_r.y};
    case (scr_r)
      SCR_NORTH: begin
        d2 = w35 + ez2;  lnum = -w35 - ex2;  rnum = w35 - ex2;
        tr = -{{2{eye_r.x[31]}}, eye_r.x};
        tn = -{{2{eye_r.z[31]}}, eye_r.z};
      end
      SCR_WEST: begin
        d2 = w35 + ex2;  lnum = ez2 - w35;   rnum = w35 + ez2;
        tr = {{2{eye_r.z[31]}}, eye_r.z};
        tn = -{{2{eye_r.x[31]}}, eye_r.x};
      end
      default: begin
        d2 = w35 - ex2;  lnum = -w35 - ez2;  rnum = w35 - ez2;
        tr = -{{2{eye_r.z[31]}}, eye_r.z};
        tn = {{2{eye_r.x[31]}}, eye_r.x};
      end
    endcase
    op_den = 35'sd1;
    op_b   = 34'(Q_ONE);
    case (step_r)
      STEP_L:  begin op_a = lnum; op_b = n35[33:0]; op_den = d2; end
      STEP_R:  begin op_a = rnum; op_b = n35[33:0]; op_den = d2; end
      STEP_B:  begin op_a = -h35 - ey2; op_b = n35[33:0]; op_den = d2; end
      STEP_T:  begin op_a = h35 - ey2;  op_b = n35[33:0]; op_den = d2; end
      STEP_A:  begin op_a = n35 <<< 1; op_den = 35'(r_r) - 35'(l_r); end
      STEP_C:  begin op_a = 35'(r_r) + 35'(l_r); op_den = 35'(r_r) - 35'(l_r); end
      STEP_BC: begin op_a = n35 <<< 1; op_den = 35'(t_r) - 35'(b_r); end
      STEP_D:  begin op_a = 35'(t_r) + 35'(b_r); op_den = 35'(t_r) - 35'(b_r); end
      STEP_E:  begin op_a = -(f35 + n35); op_den = f35 - n35; end
      STEP_F:  begin op_a = -(f35 <<< 1); op_b = n35[33:0]; op_den = f35 - n35; end
      STEP_AT: begin op_a = 35'(a_r);  op_b = tr; end
      STEP_CT: begin op_a = 35'(c_r);  op_b = tn; end
      STEP_BT: begin op_a = 35'(bc_r); op_b = tu; end
      STEP_DT: begin op_a = 35'(d_r);  op_b = tn; end
      default: begin op_a = 35'(e_r);  op_b = tn; end
    endcase
    am_w   = op_a[34] ? 35'(-op_a) : 35'(op_a);
    bm_w   = op_b[33] ? 34'(-op_b) : 34'(op_b);
    dm_w   = op_den[34] ? 35'(-op_den) : 35'(op_den);
    prod_w = am_w[32:0] * bm_w[31:0];
  end

  assign is_div = (step_r <= STEP_F);

  // Product rounded from Q32.32 back to Q16.16
  assign rnd_sum = prod_r + 64'd32768;
  assign term    = neg_r ? -$signed({2'b0, rnd_sum[63:16]}) : $signed({2'b0, rnd_sum[63:16]});

  assign div_req.start = (state_r == ST_START);
  assign div_req.num   = prod_r;
  assign div_req.den   = dmag_r;
  assign div_req.neg   = neg_r;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_load = (state_r == ST_OUT) && (!out_valid || !out_stall);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      scr_r   <= '0;
      row_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            state_r <= ST_MUL;
            step_r  <= STEP_L;
            scr_r   <= SCR_NORTH;
          end
        end
        ST_MUL: begin
          if (is_div) begin
            state_r <= ST_START;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (!is_div || div_rsp.done) begin
            if (step_r == STEP_ET) begin
              state_r <= ST_OUT;
              row_r   <= '0;
            end else begin
              state_r <= ST_MUL;
              step_r  <= step_r + 4'd1;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            row_r <= row_r + 2'd1;
            if (row_r == 2'd3) begin
              if (scr_r == LAST_SCR) begin
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_MUL;
                step_r  <= STEP_L;
                scr_r   <= scr_r + 2'd1;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      eye_r <= q_eye;
    end
    if (state_r == ST_MUL) begin
      prod_r <= prod_w[63:0];
      dmag_r <= dm_w[32:0];
      neg_r  <= op_a[34] ^ op_b[33] ^ op_den[34];
      if (step_r == STEP_L) begin
        deg_r <= 1'b0;
      end
    end
    if (state_r == ST_DIV && is_div && div_rsp.done) begin
      deg_r <= deg_r | div_rsp.zdiv;
      case (step_r)
        STEP_L:  l_r  <= div_rsp.quot;
        STEP_R:  r_r  <= div_rsp.quot;
        STEP_B:  b_r  <= div_rsp.quot;
        STEP_T:  t_r  <= div_rsp.quot;
        STEP_A:  a_r  <= div_rsp.quot;
        STEP_C:  c_r  <= div_rsp.quot;
        STEP_BC: bc_r <= div_rsp.quot;
        STEP_D:  d_r  <= div_rsp.quot;
        STEP_E:  e_r  <= div_rsp.quot;
        default: f_r  <= div_rsp.quot;
      endcase
    end
    // Translation column sums
    if (state_r == ST_DIV && !is_div) begin
      case (step_r)
        STEP_AT: acc_r   <= term;
        STEP_CT: row03_r <= sat32(acc_r + term);
        STEP_BT: acc_r   <= term;
        STEP_DT: row13_r <= sat32(acc_r + term);
        default: row23_r <= sat32(term + 50'(f_r));
      endcase
    end
  end

  // Row assembly per screen
  always_comb begin
    el0 = '0; el1 = '0; el2 = '0; el3 = '0;
    case (scr_r)
      SCR_NORTH: begin
        case (row_r)
          2'd0:    begin el0 = a_r;  el2 = c_r; el3 = row03_r; end
          2'd1:    begin el1 = bc_r; el2 = d_r; el3 = row13_r; end
          2'd2:    begin el2 = e_r;  el3 = row23_r; end
          default: begin el2 = -Q_ONE; el3 = eye_r.z; end
        endcase
      end
      SCR_WEST: begin
        case (row_r)
          2'd0:    begin el0 = c_r; el2 = neg_sat(a_r); el3 = row03_r; end
          2'd1:    begin el0 = d_r; el1 = bc_r; el3 = row13_r; end
          2'd2:    begin el0 = e_r; el3 = row23_r; end
          default: begin el0 = -Q_ONE; el3 = eye_r.x; end
        endcase
      end
      default: begin
        case (row_r)
          2'd0:    begin el0 = neg_sat(c_r); el2 = a_r; el3 = row03_r; end
          2'd1:    begin el0 = neg_sat(d_r); el1 = bc_r; el3 = row13_r; end
          2'd2:    begin el0 = neg_sat(e_r); el3 = row23_r; end
          default: begin el0 = Q_ONE; el3 = neg_sat(eye_r.x); end
        endcase
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_screen_index <= scr_r;
      out_row_index    <= row_r;
      out_elem0        <= el0;
      out_elem1        <= el1;
      out_elem2        <= el2;
      out_elem3        <= el3;
      out_degenerate   <= deg_r;
      out_last         <= (scr_r == LAST_SCR) && (row_r == 2'd3);
    end
  end

endmodule

// File: rtl/off_axis_projection_matrix.sv
// Top level of the off-axis projection matrix generator.
//
// Input channel (in_valid / in_stall): one eye position per transfer, three
// signed Q16.16 coordinates. A two-entry queue takes positions while the
// back end is still working on earlier ones.
// Result channel (out_valid / out_stall): four matrix rows per screen,
// screens 0 up to SCREEN_COUNT-1 in order; out_last marks the final row.
// Configuration: cfg_we / cfg_index / cfg_wdata write width, height, near
// and far clip; write only while the block is idle.
// Sequencing: each screen runs ten rounding divisions on one shared
// bit-serial divider (which finishes early when the result saturates at
// once) and five multiply-round steps, then emits its four rows. A new eye
// position leaves the queue only after the last row of the previous one.
// Reset (synchronous, rst_n low) empties the queue, idles the sequencer and
// restores the register defaults. A stalled result holds in the output
// register and the sequencer waits; the input queue keeps taking positions
// until it holds two, then stalls the input.
module off_axis_projection_matrix #(
  parameter int SCREEN_COUNT = opm_pkg::SCREEN_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_eye_x,
  input  logic signed [31:0]          in_eye_y,
  input  logic signed [31:0]          in_eye_z,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_screen_index,
  output logic [1:0]                  out_row_index,
  output logic signed [31:0]          out_elem0,
  output logic signed [31:0]          out_elem1,
  output logic signed [31:0]          out_elem2,
  output logic signed [31:0]          out_elem3,
  output logic                        out_degenerate,
  output logic                        out_last,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [opm_pkg::CFG_W-1:0]   cfg_wdata
);
  import opm_pkg::*;

  logic [CFG_W-1:0] width_r, height_r, near_r, far_r;
  eye_t     in_eye, q_eye;
  logic     q_valid, q_pop;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_eye = '{x: in_eye_x, y: in_eye_y, z: in_eye_z};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DISPLAY_WIDTH_RST;
      height_r <= DISPLAY_HEIGHT_RST;
      near_r   <= NEAR_CLIP_RST;
      far_r    <= FAR_CLIP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISPLAY_WIDTH:  width_r  <= cfg_wdata;
        CFG_DISPLAY_HEIGHT: height_r <= cfg_wdata;
        CFG_NEAR_CLIP:      near_r   <= cfg_wdata;
        CFG_FAR_CLIP:       far_r    <= cfg_wdata;
        default:            width_r  <= width_r;
      endcase
    end
  end

  opm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_eye   (in_eye),
    .q_valid  (q_valid),
    .q_eye    (q_eye),
    .q_pop    (q_pop)
  );

  opm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  opm_back #(
    .SCREEN_COUNT (SCREEN_COUNT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .width_q          (width_r),
    .height_q         (height_r),
    .near_q           (near_r),
    .far_q            (far_r),
    .q_valid          (q_valid),
    .q_eye            (q_eye),
    .q_pop            (q_pop),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_screen_index (out_screen_index),
    .out_row_index    (out_row_index),
    .out_elem0        (out_elem0),
    .out_elem1        (out_elem1),
    .out_elem2        (out_elem2),
    .out_elem3        (out_elem3),
    .out_degenerate   (out_degenerate),
    .out_last         (out_last)
  );

endmodule

// File: sim/off_axis_projection_matrix_chk.sv
// Checker for the off-axis projection block: predicts matrix rows and compares them.
`timescale 1ns / 100ps

module off_axis_projection_matrix_chk #(
  parameter int SCREEN_COUNT = opm_pkg::SCREEN_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [31:0]        in_eye_x,
  input  logic signed [31:0]        in_eye_y,
  input  logic signed [31:0]        in_eye_z,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [1:0]                out_screen_index,
  input  logic [1:0]                out_row_index,
  input  logic signed [31:0]        out_elem0,
  input  logic signed [31:0]        out_elem1,
  input  logic signed [31:0]        out_elem2,
  input  logic signed [31:0]        out_elem3,
  input  logic                      out_degenerate,
  input  logic                      out_last,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [opm_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        rows_pending
);
  import opm_pkg::*;

  localparam longint unsigned QUOT_CAP = 64'd1 << 61;
  localparam longint ONE = 65536;

  typedef struct packed {
    logic [1:0]  screen;
    logic [1:0]  row;
    logic [31:0] e0;
    logic [31:0] e1;
    logic [31:0] e2;
    logic [31:0] e3;
    logic        deg;
    logic        last;
  } mat_row_t;

  mat_row_t row_q[$];
  longint width_r, height_r, near_r, far_r;

  assign rows_pending = row_q.size();

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // round(a*b/den), ties away from zero; zero divisor flags, saturates unless a*b is 0
  function automatic longint round_div(longint a, longint b, longint den, inout bit deg);
    longint unsigned p, md, q, rem;
    bit neg;
    p = magn(a) * magn(b);
    md = magn(den);
    neg = ((a < 0) != (b < 0)) != (den < 0);
    if (md == 0) begin
      deg = 1'b1;
      if (p == 0) return 0;
      q = QUOT_CAP;
    end else begin
      q = p / md;
      rem = p % md;
      if (rem >= md - rem) q++;
      if (q > QUOT_CAP) q = QUOT_CAP;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Build P * transpose(M) * T for each screen and queue its four rows
  task automatic predict_frame(longint ex, longint ey, longint ez);
    longint vr[3], vn[3], vu[3], e[3];
    longint d2, lnum, rnum, l, r, b, t, a_c, b_c, c_c, d_c, e_c, f_c, tr, tu, tn;
    longint rows[4][4];
    bit deg;
    mat_row_t m;
    e[0] = ex; e[1] = ey; e[2] = ez;
    for (int s = 0; s < SCREEN_COUNT; s++) begin
      vr = '{0, 0, 0}; vn = '{0, 0, 0}; vu = '{0, 1, 0};
      deg = 1'b0;
      if (s == SCR_NORTH) begin
        d2 = width_r + 2 * ez; lnum = -width_r - 2 * ex; rnum = width_r - 2 * ex;
        vr[0] = 1; vn[2] = 1;
      end else if (s == SCR_WEST) begin
        d2 = width_r + 2 * ex; lnum = 2 * ez - width_r; rnum = width_r + 2 * ez;
        vr[2] = -1; vn[0] = 1;
      end else begin
        d2 = width_r - 2 * ex; lnum = -width_r - 2 * ez; rnum = width_r - 2 * ez;
        vr[2] = 1; vn[0] = -1;
      end
      // frustum extents at the near plane
      l = clamp_q(round_div(lnum, near_r, d2, deg));
      r = clamp_q(round_div(rnum, near_r, d2, deg));
      b = clamp_q(round_div(-height_r - 2 * ey, near_r, d2, deg));
      t = clamp_q(round_div(height_r - 2 * ey, near_r, d2, deg));
      a_c = clamp_q(round_div(2 * near_r, ONE, r - l, deg));
      c_c = clamp_q(round_div(r + l, ONE, r - l, deg));
      b_c = clamp_q(round_div(2 * near_r, ONE, t - b, deg));
      d_c = clamp_q(round_div(t + b, ONE, t - b, deg));
      e_c = clamp_q(round_div(-(far_r + near_r), ONE, far_r - near_r, deg));
      f_c = clamp_q(round_div(-2 * far_r, near_r, far_r - near_r, deg));
      tr = -(vr[0] * e[0] + vr[1] * e[1] + vr[2] * e[2]);
      tu = -(vu[0] * e[0] + vu[1] * e[1] + vu[2] * e[2]);
      tn = -(vn[0] * e[0] + vn[1] * e[1] + vn[2] * e[2]);
      for (int k = 0; k < 3; k++) begin
        rows[0][k] = a_c * vr[k] + c_c * vn[k];
        rows[1][k] = b_c * vu[k] + d_c * vn[k];
        rows[2][k] = e_c * vn[k];
        rows[3][k] = -vn[k] * ONE;
      end
      rows[0][3] = round_div(a_c, tr, ONE, deg) + round_div(c_c, tn, ONE, deg);
      rows[1][3] = round_div(b_c, tu, ONE, deg) + round_div(d_c, tn, ONE, deg);
      rows[2][3] = round_div(e_c, tn, ONE, deg) + f_c;
      rows[3][3] = -tn;
      for (int rw = 0; rw < 4; rw++) begin
        m.screen = 2'(s);
        m.row    = 2'(rw);
        m.e0     = 32'(clamp_q(rows[rw][0]));
        m.e1     = 32'(clamp_q(rows[rw][1]));
        m.e2     = 32'(clamp_q(rows[rw][2]));
        m.e3     = 32'(clamp_q(rows[rw][3]));
        m.deg    = deg;
        m.last   = (s == SCREEN_COUNT - 1) && (rw == 3);
        row_q.push_back(m);
      end
    end
  endtask

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // register copy, input prediction and result compare
  always @(posedge clk) begin
    mat_row_t m;
    if (!rst_n) begin
      width_r  <= longint'(DISPLAY_WIDTH_RST);
      height_r <= longint'(DISPLAY_HEIGHT_RST);
      near_r   <= longint'(NEAR_CLIP_RST);
      far_r    <= longint'(FAR_CLIP_RST);
      row_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_frame(in_eye_x, in_eye_y, in_eye_z);
      if (out_valid && !out_stall) begin
        if (row_q.size() == 0) begin
          $error("result row with nothing expected");
          fail_count++;
        end else begin
          m = row_q.pop_front();
          cmp_field("screen_index", 32'(m.screen), 32'(out_screen_index));
          cmp_field("row_index", 32'(m.row), 32'(out_row_index));
          cmp_field("elem0", m.e0, out_elem0);
          cmp_field("elem1", m.e1, out_elem1);
          cmp_field("elem2", m.e2, out_elem2);
          cmp_field("elem3", m.e3, out_elem3);
          cmp_field("degenerate", 32'(m.deg), 32'(out_degenerate));
          cmp_field("last", 32'(m.last), 32'(out_last));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DISPLAY_WIDTH:  width_r  <= longint'(cfg_wdata);
          CFG_DISPLAY_HEIGHT: height_r <= longint'(cfg_wdata);
          CFG_NEAR_CLIP:      near_r   <= longint'(cfg_wdata);
          CFG_FAR_CLIP:       far_r    <= longint'(cfg_wdata);
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sim/tb_off_axis_projection_matrix.sv
// Stimulus and verdict for the off-axis projection matrix block.
`timescale 1ns / 100ps

module tb_off_axis_projection_matrix;
  import opm_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_screen_index, out_row_index;
  logic signed [31:0] out_elem0, out_elem1, out_elem2, out_elem3;
  logic out_degenerate, out_last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int fail_count, rows_pending;
  int tx_idle_pct, rx_idle_pct;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  off_axis_projection_matrix dut (.*);

  off_axis_projection_matrix_chk chk (.*);

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall <= (hold_left > 1) || ($urandom_range(99) < rx_idle_pct);
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_off_axis_projection_matrix failed");
      $finish;
    end
  end

  task automatic send_eye(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_eye_x <= x;
    in_eye_y <= y;
    in_eye_z <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                            logic [CFG_W-1:0] n, logic [CFG_W-1:0] f);
    write_reg(CFG_DISPLAY_WIDTH, w);
    write_reg(CFG_DISPLAY_HEIGHT, h);
    write_reg(CFG_NEAR_CLIP, n);
    write_reg(CFG_FAR_CLIP, f);
  endtask

  // mostly within a few meters of the origin, sometimes anywhere
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(393216) - 196608;
  endfunction

  task automatic random_config();
    if ($urandom_range(4) == 0)
      set_screen(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
    else
      set_screen(31'($urandom_range(1, 262144)), 31'($urandom_range(1, 262144)),
                 31'($urandom_range(1, 65536)), 31'($urandom_range(65537, 6553600)));
  endtask

  task automatic random_eyes(int count);
    for (int i = 0; i < count; i++)
      send_eye(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    tx_idle_pct = 6;
    rx_idle_pct = 63;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes under reset registers
    send_eye(32'h0, 32'h0, 32'h0);
    send_eye(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_eye(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_eye(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_eye(32'hffff_ffff, 32'h1, 32'hffff_ffff);
    send_eye(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_eye(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    drain();

    // eye in each screen plane: zero distance
    set_screen(31'd65536, 31'd65536, 31'd6554, 31'd655360);
    send_eye(32'h0, 32'h0, -32'sd32768);
    send_eye(-32'sd32768, 32'h0, 32'h0);
    send_eye(32'sd32768, 32'h0, 32'h0);
    send_eye(32'h0, 32'sd32768, 32'h0);
    drain();

    // zero near clip gives r equal to l; then far equal to near
    write_reg(CFG_NEAR_CLIP, 31'd0);
    send_eye(32'sd1000, 32'sd2000, 32'sd3000);
    drain();
    set_screen(31'd0, 31'd0, 31'd65536, 31'd65536);
    send_eye(32'sd1000, -32'sd2000, 32'sd3000);
    drain();

    // register extremes
    set_screen(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    send_eye(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
    send_eye(32'h0, 32'h0, 32'h0);
    drain();
    set_screen(31'd1, 31'd1, 31'd1, 31'd1);
    send_eye(32'h1, 32'hffff_ffff, 32'h0);
    send_eye(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    drain();

    // random frames: sender rarely idle, receiver often
    random_config();
    random_eyes(27);
    drain();
    random_config();
    random_eyes(27);
    drain();

    // swap who idles
    tx_idle_pct = 63;
    rx_idle_pct = 6;
    random_config();
    random_eyes(27);
    drain();
    random_config();
    random_eyes(27);
    drain();

    // no idling, with one long receiver hold-off to back up the input
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_config();
    hold_req <= 1'b1;
    random_eyes(26);
    drain();
    random_config();
    random_eyes(26);
    drain();

    repeat (200) @(posedge clk);
    if (fail_count == 0 && rows_pending == 0)
      $display("tb_off_axis_projection_matrix passed");
    else
      $display("tb_off_axis_projection_matrix failed");
    $finish;
  end

endmodule
